[design/huffman_tree_walk_decoder_assert.svh]
// assertion macros for the huffman tree-walk decoder
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, clocked on i_clk, off during reset
`define HUFW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hufw assertion failed");
// next-cycle implication, clocked on i_clk, off during reset
`define HUFW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hufw assertion failed");
`else
`define HUFW_ASSERT_SAME(lbl, ante, cons)
`define HUFW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/hufw_pkg.sv]
package hufw_pkg;

    localparam logic [7:0] STAR_BYTE      = 8'h2A;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam int         TOP_BIT        = 7;
    localparam int         BYTE_BITS      = TOP_BIT + 1;
    localparam int         CNT_W          = 4;

    // func codes
    localparam logic FN_TREE = 1'b0;
    localparam logic FN_DATA = 1'b1;

    // status codes
    localparam logic ST_SYMBOL = 1'b0;
    localparam logic ST_ERROR  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
        logic       segment_end;
        logic [2:0] pad_bits;
    } t_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       run_end;
    } t_result;

    // node table write controls, builder to walker
    typedef struct packed {
        logic sym_we;
        logic is_leaf;
        logic link_we;
        logic link_right;
    } t_node_ctl;

endpackage

[design/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder. Words are offered on i_item with start and are
// taken at a clock edge where start is high and busy is low. A tree word
// (func 0) carries one byte of a pre-order serialized tree: '*' opens an
// internal node, a backslash before '*' gives a '*' leaf, anything else is a
// leaf. Tree words give no results and keep busy high for the node writes
// and, after a right-child leaf closes a non-root parent, for a reload of
// the parent stack, which sits in a memory, via B_POPRD and B_POPLD. A data
// word (func 1) is shifted out MSB first, one code bit per cycle unless
// a leaf hit with a bad root child holds the bit, each bit one read of the
// node table; busy stays high through the W_BIT bit steps, W_FIN to settle a
// leaf reached on the last bit and W_FLUSH to drain, so no word is taken
// mid-walk; pad_bits trims the final word's bit steps. A data word with no
// good tree gives a single error result. Results come out on o_result for
// exactly one cycle with o_strobe high, in order, the last one of each word
// with run_end set; the receiver cannot stall them, so it must take every
// strobe. Up to eight results come from one data word. The node table needs
// no clearing after reset: only nodes already written are ever used.
module huffman_tree_walk_decoder #(
    parameter int TREE_NODES  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hufw_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output hufw_pkg::t_result o_result
);
    import hufw_pkg::*;

`include "huffman_tree_walk_decoder_assert.svh"

    localparam int NW = $clog2(TREE_NODES);
    localparam int CW = $clog2(TREE_NODES + 1);

    logic          accept;
    logic          tree_go;
    logic          data_go;
    logic          build_busy;
    logic          walk_busy;
    t_node_ctl     wr_ctl;
    logic [NW-1:0] wr_idx;
    logic [7:0]    wr_sym;
    logic [NW-1:0] link_addr;
    logic [NW-1:0] link_val;
    logic [CW-1:0] node_count;
    logic          tree_ok;

    // a word is taken only when both halves are idle
    assign busy    = build_busy || walk_busy;
    assign accept  = start && !busy;
    assign tree_go = accept && (i_item.func == FN_TREE);
    assign data_go = accept && (i_item.func == FN_DATA);

    // tree builder: pre-order parse, open parent stack, node writes
    hufw_tree_build #(
        .TREE_NODES  (TREE_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_build (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (tree_go),
        .i_item       (i_item),
        .o_busy       (build_busy),
        .o_wr_ctl     (wr_ctl),
        .o_wr_idx     (wr_idx),
        .o_wr_sym     (wr_sym),
        .o_link_addr  (link_addr),
        .o_link_val   (link_val),
        .o_node_count (node_count),
        .o_tree_ok    (tree_ok)
    );

    // bit-serial walker: owns the node table and the result register;
    // any tree word sends the walk back to the root
    hufw_bit_walk #(
        .TREE_NODES (TREE_NODES)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (data_go),
        .i_clr        (tree_go),
        .i_item       (i_item),
        .i_tree_ok    (tree_ok),
        .i_node_count (node_count),
        .i_wr_ctl     (wr_ctl),
        .i_wr_idx     (wr_idx),
        .i_wr_sym     (wr_sym),
        .i_link_addr  (link_addr),
        .i_link_val   (link_val),
        .o_busy       (walk_busy),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    // a taken word always keeps the block busy for the next cycle
    `HUFW_ASSERT_NEXT(a_accept_busy, accept, busy)
    // an error result always closes its word
    `HUFW_ASSERT_SAME(a_error_ends, o_strobe && (o_result.status == ST_ERROR), o_result.run_end)
    // tree words never produce a result
    `HUFW_ASSERT_NEXT(a_tree_quiet, tree_go, !o_strobe)
    // the builder and the walker never run together
    `HUFW_ASSERT_SAME(a_one_side, build_busy, !walk_busy)

endmodule

[design/hufw_tree_build.sv]
module hufw_tree_build #(
    parameter int TREE_NODES  = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  hufw_pkg::t_item                   i_item,
    output logic                              o_busy,
    output hufw_pkg::t_node_ctl               o_wr_ctl,
    output logic [$clog2(TREE_NODES)-1:0]     o_wr_idx,
    output logic [7:0]                        o_wr_sym,
    output logic [$clog2(TREE_NODES)-1:0]     o_link_addr,
    output logic [$clog2(TREE_NODES)-1:0]     o_link_val,
    output logic [$clog2(TREE_NODES+1)-1:0]   o_node_count,
    output logic                              o_tree_ok
);
    import hufw_pkg::*;

    localparam int NW  = $clog2(TREE_NODES);
    localparam int CW  = $clog2(TREE_NODES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SDW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_NODE  = 3'd1;
    localparam logic [2:0] B_POPRD = 3'd2;
    localparam logic [2:0] B_POPLD = 3'd3;
    localparam logic [2:0] B_FIN   = 3'd4;

    logic [2:0]     r_state, n_state;
    logic           r_n0_v, n_n0_v, r_n0_leaf, n_n0_leaf;
    logic [7:0]     r_n0_sym, n_n0_sym;
    logic           r_n1_v, n_n1_v, r_n1_leaf, n_n1_leaf;
    logic [7:0]     r_n1_sym, n_n1_sym;
    logic           r_last, n_last;
    logic           r_escape, n_escape;
    logic           r_ready, n_ready;
    logic           r_bad, n_bad;
    logic [CW-1:0]  r_count, n_count;
    logic [SDW-1:0] r_depth, n_depth;
    logic [NW-1:0]  r_top, n_top;
    logic           r_top_full, n_top_full;
    logic           r_root_leaf, n_root_leaf;
    logic [NW-1:0]  r_stk_q;

    logic [NW-1:0]  m_stk [STACK_DEPTH];

    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [SAW-1:0] stk_raddr;
    logic [SDW-1:0] d1;
    logic [SDW-1:0] d1m;
    logic [SDW-1:0] depth_m1;
    logic           popped;
    logic           reload;
    logic           b_star, b_bs, b_node, esc_now;
    t_node_ctl      wr_ctl;

    // top of the stack lives in r_top, entries below it in m_stk
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            m_stk[stk_waddr] <= r_top;
        end
        r_stk_q <= m_stk[stk_raddr];
    end

    assign depth_m1  = r_depth - SDW'(1);
    assign stk_raddr = depth_m1[SAW-1:0];

    always_comb begin
        n_state     = r_state;
        n_n0_v      = r_n0_v;
        n_n0_leaf   = r_n0_leaf;
        n_n0_sym    = r_n0_sym;
        n_n1_v      = r_n1_v;
        n_n1_leaf   = r_n1_leaf;
        n_n1_sym    = r_n1_sym;
        n_last      = r_last;
        n_escape    = r_escape;
        n_ready     = r_ready;
        n_bad       = r_bad;
        n_count     = r_count;
        n_depth     = r_depth;
        n_top       = r_top;
        n_top_full  = r_top_full;
        n_root_leaf = r_root_leaf;
        wr_ctl      = '0;
        stk_we      = 1'b0;
        d1          = r_depth;
        d1m         = r_depth;
        popped      = 1'b0;
        reload      = 1'b0;
        b_star      = (i_item.byte_value == STAR_BYTE);
        b_bs        = (i_item.byte_value == BACKSLASH_BYTE);
        b_node      = !(b_bs && !i_item.segment_end);
        esc_now     = r_escape && !r_ready;

        unique case (r_state)
            B_IDLE: begin
                if (i_go) begin
                    // a finished tree is thrown away by the next tree word
                    if (r_ready) begin
                        n_ready    = 1'b0;
                        n_bad      = 1'b0;
                        n_count    = '0;
                        n_depth    = '0;
                    end
                    n_last    = i_item.segment_end;
                    n_n1_v    = 1'b0;
                    n_n1_leaf = !b_star;
                    n_n1_sym  = i_item.byte_value;
                    if (esc_now && b_star) begin
                        n_n0_v    = 1'b1;
                        n_n0_leaf = 1'b1;
                        n_n0_sym  = STAR_BYTE;
                        n_escape  = 1'b0;
                    end else if (esc_now) begin
                        n_n0_v    = 1'b1;
                        n_n0_leaf = 1'b1;
                        n_n0_sym  = BACKSLASH_BYTE;
                        n_n1_v    = b_node;
                        n_escape  = !b_node;
                    end else begin
                        n_n0_v    = b_node;
                        n_n0_leaf = !b_star;
                        n_n0_sym  = i_item.byte_value;
                        n_escape  = !b_node;
                    end
                    n_state = B_NODE;
                end
            end
            B_NODE: begin
                if (r_n0_v && !r_bad) begin
                    if (r_count >= CW'(TREE_NODES) || (r_count != '0 && r_depth == '0)) begin
                        n_bad = 1'b1;
                    end else begin
                        wr_ctl.sym_we  = 1'b1;
                        wr_ctl.is_leaf = r_n0_leaf;
                        n_count        = r_count + CW'(1);
                        if (r_count == '0) begin
                            n_root_leaf = r_n0_leaf;
                        end else begin
                            wr_ctl.link_we    = 1'b1;
                            wr_ctl.link_right = r_top_full;
                            n_top_full        = 1'b1;
                            if (r_top_full) begin
                                popped = 1'b1;
                                d1     = r_depth - SDW'(1);
                            end
                        end
                        d1m = d1 - SDW'(1);
                        if (!r_n0_leaf) begin
                            if (d1 >= SDW'(STACK_DEPTH)) begin
                                n_bad = 1'b1;
                            end else begin
                                stk_we     = !popped && (d1 != '0);
                                n_top      = r_count[NW-1:0];
                                n_top_full = 1'b0;
                                d1         = d1 + SDW'(1);
                            end
                        end else if (popped && d1 != '0) begin
                            reload = 1'b1;
                        end
                        n_depth = d1;
                    end
                end
                n_n0_v    = r_n1_v;
                n_n0_leaf = r_n1_leaf;
                n_n0_sym  = r_n1_sym;
                n_n1_v    = 1'b0;
                if (reload) begin
                    n_state = B_POPRD;
                end else if (r_n1_v) begin
                    n_state = B_NODE;
                end else begin
                    n_state = r_last ? B_FIN : B_IDLE;
                end
            end
            B_POPRD: begin
                n_state = B_POPLD;
            end
            B_POPLD: begin
                n_top = r_stk_q;
                if (r_n0_v) begin
                    n_state = B_NODE;
                end else begin
                    n_state = r_last ? B_FIN : B_IDLE;
                end
            end
            B_FIN: begin
                if (r_depth != '0 || r_count == '0 || r_root_leaf) begin
                    n_bad = 1'b1;
                end
                n_ready  = 1'b1;
                n_escape = 1'b0;
                n_state  = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign stk_waddr = d1m[SAW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_n0_v     <= 1'b0;
            r_n1_v     <= 1'b0;
            r_last     <= 1'b0;
            r_escape   <= 1'b0;
            r_ready    <= 1'b0;
            r_bad      <= 1'b0;
            r_count    <= '0;
            r_depth    <= '0;
            r_top_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n0_v     <= n_n0_v;
            r_n1_v     <= n_n1_v;
            r_last     <= n_last;
            r_escape   <= n_escape;
            r_ready    <= n_ready;
            r_bad      <= n_bad;
            r_count    <= n_count;
            r_depth    <= n_depth;
            r_top_full <= n_top_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n0_leaf   <= n_n0_leaf;
        r_n0_sym    <= n_n0_sym;
        r_n1_leaf   <= n_n1_leaf;
        r_n1_sym    <= n_n1_sym;
        r_top       <= n_top;
        r_root_leaf <= n_root_leaf;
    end

    assign o_busy       = (r_state != B_IDLE);
    assign o_wr_ctl     = wr_ctl;
    assign o_wr_idx     = r_count[NW-1:0];
    assign o_wr_sym     = r_n0_sym;
    assign o_link_addr  = r_top;
    assign o_link_val   = r_count[NW-1:0];
    assign o_node_count = r_count;
    assign o_tree_ok    = r_ready && !r_bad;

endmodule

[design/hufw_bit_walk.sv]
module hufw_bit_walk #(
    parameter int TREE_NODES = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic                            i_clr,
    input  hufw_pkg::t_item                 i_item,
    input  logic                            i_tree_ok,
    input  logic [$clog2(TREE_NODES+1)-1:0] i_node_count,
    input  hufw_pkg::t_node_ctl             i_wr_ctl,
    input  logic [$clog2(TREE_NODES)-1:0]   i_wr_idx,
    input  logic [7:0]                      i_wr_sym,
    input  logic [$clog2(TREE_NODES)-1:0]   i_link_addr,
    input  logic [$clog2(TREE_NODES)-1:0]   i_link_val,
    output logic                            o_busy,
    output logic                            o_strobe,
    output hufw_pkg::t_result               o_result
);
    import hufw_pkg::*;

    localparam int NW = $clog2(TREE_NODES);
    localparam int CW = $clog2(TREE_NODES + 1);

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_BIT   = 2'd1;
    localparam logic [1:0] W_FIN   = 2'd2;
    localparam logic [1:0] W_FLUSH = 2'd3;

    localparam t_result ERR_RESULT = '{symbol: 8'd0, status: ST_ERROR, run_end: 1'b0};

    logic [8:0]    m_info  [TREE_NODES];
    logic [NW-1:0] m_left  [TREE_NODES];
    logic [NW-1:0] m_right [TREE_NODES];

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_sh, n_sh;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_cur_root, n_cur_root;
    logic [NW-1:0]    r_raddr, n_raddr;
    logic             r_pend_v, n_pend_v;
    t_result          r_pend, n_pend;
    logic             r_out_v, n_out_v;
    t_result          r_out, n_out;
    logic             q_leaf;
    logic [7:0]       q_sym;
    logic [NW-1:0]    q_left, q_right;
    logic [NW-1:0]    r_root_l, r_root_r;

    logic             leaf_hit, use_root, bad_child, emit_v;
    logic [NW-1:0]    lnk_l, lnk_r, child;
    t_result          emit;

    // node table, written while the tree is built, read one node per code bit
    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.sym_we) begin
            m_info[i_wr_idx] <= {i_wr_ctl.is_leaf, i_wr_sym};
        end
        if (i_wr_ctl.link_we && i_wr_ctl.link_right) begin
            m_right[i_link_addr] <= i_link_val;
        end
        if (i_wr_ctl.link_we && !i_wr_ctl.link_right) begin
            m_left[i_link_addr] <= i_link_val;
        end
        {q_leaf, q_sym} <= m_info[n_raddr];
        q_left          <= m_left[n_raddr];
        q_right         <= m_right[n_raddr];
    end

    // root links kept aside so a walk from the root needs no read
    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.link_we && i_link_addr == '0) begin
            if (i_wr_ctl.link_right) begin
                r_root_r <= i_link_val;
            end else begin
                r_root_l <= i_link_val;
            end
        end
    end

    assign leaf_hit  = !r_cur_root && q_leaf;
    assign use_root  = r_cur_root || q_leaf;
    assign lnk_l     = use_root ? r_root_l : q_left;
    assign lnk_r     = use_root ? r_root_r : q_right;
    assign child     = r_sh[TOP_BIT] ? lnk_r : lnk_l;
    assign bad_child = (child == '0) || (CW'(child) >= i_node_count);

    always_comb begin
        n_state    = r_state;
        n_sh       = r_sh;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_cur_root = r_cur_root;
        n_raddr    = r_raddr;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = 1'b0;
        n_out      = r_out;
        emit_v     = 1'b0;
        emit       = ERR_RESULT;

        unique case (r_state)
            W_IDLE: begin
                if (i_clr) begin
                    n_cur_root = 1'b1;
                end
                if (i_go) begin
                    if (!i_tree_ok) begin
                        emit_v     = 1'b1;
                        n_cur_root = 1'b1;
                        n_state    = W_FLUSH;
                    end else begin
                        n_sh    = i_item.byte_value;
                        n_cnt   = i_item.segment_end ?
                                  CNT_W'(BYTE_BITS) - CNT_W'(i_item.pad_bits) :
                                  CNT_W'(BYTE_BITS);
                        n_last  = i_item.segment_end;
                        n_state = W_BIT;
                    end
                end
            end
            W_BIT: begin
                if (leaf_hit) begin
                    emit_v      = 1'b1;
                    emit.symbol = q_sym;
                    emit.status = ST_SYMBOL;
                end
                if (bad_child && leaf_hit) begin
                    // hold the bit, the error is taken from the root next cycle
                    n_cur_root = 1'b1;
                end else if (bad_child) begin
                    emit_v     = 1'b1;
                    n_cur_root = 1'b1;
                    n_state    = W_FLUSH;
                end else begin
                    n_raddr    = child;
                    n_cur_root = 1'b0;
                    n_sh       = {r_sh[TOP_BIT-1:0], 1'b0};
                    n_cnt      = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = W_FIN;
                    end
                end
            end
            W_FIN: begin
                if (leaf_hit) begin
                    emit_v      = 1'b1;
                    emit.symbol = q_sym;
                    emit.status = ST_SYMBOL;
                    n_cur_root  = 1'b1;
                end
                // end of data drops any partial code
                if (r_last) begin
                    n_cur_root = 1'b1;
                end
                n_state = W_FLUSH;
            end
            W_FLUSH: begin
                if (r_pend_v) begin
                    n_out_v       = 1'b1;
                    n_out         = r_pend;
                    n_out.run_end = 1'b1;
                end
                n_pend_v = 1'b0;
                n_state  = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase

        // one result held back so the last one of a word can carry run_end
        if (emit_v) begin
            if (r_pend_v) begin
                n_out_v       = 1'b1;
                n_out         = r_pend;
                n_out.run_end = 1'b0;
            end
            n_pend   = emit;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= W_IDLE;
            r_cur_root <= 1'b1;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_root <= n_cur_root;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh    <= n_sh;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_raddr <= n_raddr;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_busy   = (r_state != W_IDLE);
    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule
